// ----- sv/tpp_pkg.sv -----
// Shared types and constants for the trapezoidal position profiler.
// No dependencies; imported by tpp_search and trapezoidal_position_profiler.
package tpp_pkg;

    localparam int POS_W = 32;   // position fields
    localparam int SPD_W = 8;    // signed speed, hold-off counters
    localparam int MS_W  = 7;    // top speed register, increment, index
    localparam int AP_W  = 8;    // accel_period register
    localparam int IDX_W = 1;    // configuration register index

    localparam logic [IDX_W-1:0] CFG_MAX_SPEED    = 1'b0;
    localparam logic [IDX_W-1:0] CFG_ACCEL_PERIOD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ABS,
        ST_DIST,
        ST_SEARCH,
        ST_STEP,
        ST_SPEED,
        ST_NEXT
    } tpp_state_t;

    typedef struct packed {
        logic            done;
        logic [MS_W-1:0] inc;
    } search_res_t;

endpackage

// ----- sv/tpp_search.sv -----
// Deceleration threshold search: one threshold compared per cycle.
// Depends on tpp_pkg.
module tpp_search #(
    parameter int THR_W = 22
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start_i,
    input  logic [tpp_pkg::POS_W-1:0] dist_i,
    input  logic [tpp_pkg::MS_W-1:0]  size_i,
    input  logic [tpp_pkg::AP_W-1:0]  accel_i,
    output tpp_pkg::search_res_t      res_o
);
    import tpp_pkg::*;

    logic             busy_reg;
    logic [MS_W-1:0]  idx_reg;
    logic [THR_W-1:0] step_reg;   // accel * (idx + 1)
    logic [THR_W-1:0] thr_reg;    // accel * (idx + 1) * (idx + 2) / 2
    logic [THR_W-1:0] accel_ext;
    logic             at_end;
    logic             below;

    assign accel_ext = {{(THR_W-AP_W){1'b0}}, accel_i};
    assign at_end    = (idx_reg == size_i);
    assign below     = (dist_i < {{(POS_W-THR_W){1'b0}}, thr_reg});

    always_comb begin
        res_o.done = busy_reg && (at_end || below);
        res_o.inc  = at_end ? size_i : idx_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start_i) begin
            busy_reg <= 1'b1;
        end else if (res_o.done) begin
            busy_reg <= 1'b0;
        end
    end

    // Advance the running threshold by accel * (idx + 2) each cycle while the search is busy and not done.
    always_ff @(posedge aclk) begin
        if (start_i) begin
            idx_reg  <= '0;
            step_reg <= accel_ext;
            thr_reg  <= accel_ext;
        end else if (busy_reg && !res_o.done) begin
            idx_reg  <= idx_reg + 1'b1;
            step_reg <= step_reg + accel_ext;
            thr_reg  <= thr_reg + step_reg + accel_ext;
        end
    end

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg <= size_i)
        else $error("search index passed the threshold count");

    a_inc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_o.done |-> res_o.inc <= size_i)
        else $error("search increment above threshold count");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_o.done && !start_i) |=> !busy_reg)
        else $error("search stayed busy after completion");

endmodule

// ----- sv/trapezoidal_position_profiler.sv -----
// Trapezoidal position profiler: one setpoint and signed speed per input item.
// An accepted item passes the states DIFF, ABS, DIST, SEARCH (threshold search), STEP,
// SPEED and NEXT into the output register; a new item is taken only in IDLE, after
// the last one has left NEXT, and a stalled result holds the next item in NEXT.
// Reset (aresetn low, synchronous): speed and hold-offs clear, top speed = 16,
// accel_period = 4, no item pending. Depends on tpp_pkg and tpp_search.
module trapezoidal_position_profiler #(
    parameter int MAX_SPEED_LIMIT = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [tpp_pkg::IDX_W-1:0]        cfg_index,
    input  logic [tpp_pkg::AP_W-1:0]         cfg_wdata,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [tpp_pkg::POS_W-1:0] s_present_position,
    input  logic signed [tpp_pkg::POS_W-1:0] s_goal_position,
    // result items
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [tpp_pkg::POS_W-1:0] m_next_position,
    output logic signed [tpp_pkg::SPD_W-1:0] m_speed_now
);
    import tpp_pkg::*;

    // The top speed register is 7 bits wide, so the threshold count never exceeds 127.
    localparam int SIZE_MAX = (MAX_SPEED_LIMIT < 127) ? MAX_SPEED_LIMIT : 127;
    // Widest threshold the search can reach, accel * (n+1) * (n+2) / 2.
    localparam int THR_W = $clog2(255 * (SIZE_MAX + 1) * (SIZE_MAX + 2) / 2 + 1);
    localparam int ADD_W = POS_W + 2;

    tpp_state_t state_reg, state_next;

    // configuration
    logic [MS_W-1:0] top_speed_reg;
    logic [AP_W-1:0] accel_period_reg;

    // profile state
    logic signed [SPD_W-1:0] speed_reg, speed_next;
    logic [SPD_W-1:0]        down_reg, down_next;
    logic [SPD_W-1:0]        up_reg, up_next;

    // per-item working registers
    logic signed [POS_W-1:0] cur_reg;
    logic signed [POS_W-1:0] goal_reg;
    logic [ADD_W-1:0]        diff_reg;   // goal - cur
    logic [POS_W-1:0]        mag_reg;    // |goal - cur|
    logic [POS_W-1:0]        dist_reg;   // clamp(|goal - cur| - |speed|)
    logic [MS_W-1:0]         inc_reg;
    logic signed [SPD_W-1:0] wanted_reg;

    // output register
    logic                    m_valid_reg;
    logic signed [POS_W-1:0] next_pos_reg;
    logic signed [SPD_W-1:0] speed_out_reg;

    // shared adder
    logic [ADD_W-1:0] op_a, op_b, sum;
    logic             op_cin;

    logic [MS_W-1:0]  size;
    logic [SPD_W-1:0] speed_mag;
    logic [SPD_W-1:0] reload;
    logic             search_start;
    logic             out_free;
    logic             dir_neg;
    logic [POS_W-1:0] sat_pos;
    search_res_t      search_res;

    // Above the limit, the threshold count is the limit itself.
    assign size = (32'(top_speed_reg) > MAX_SPEED_LIMIT) ? MS_W'(SIZE_MAX) : top_speed_reg;

    assign speed_mag = speed_reg[SPD_W-1] ? SPD_W'(-speed_reg) : SPD_W'(speed_reg);
    assign reload    = (accel_period_reg == '0) ? '0 : accel_period_reg - 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign dir_neg   = diff_reg[ADD_W-1];   // goal below present position

    // One adder serves every wide step; operands follow the sequencer.
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_cin = 1'b0;
        case (state_reg)
            ST_DIFF: begin
                op_a   = {{2{goal_reg[POS_W-1]}}, goal_reg};
                op_b   = ~{{2{cur_reg[POS_W-1]}}, cur_reg};
                op_cin = 1'b1;
            end
            ST_ABS: begin
                op_a   = dir_neg ? ~diff_reg : diff_reg;
                op_cin = dir_neg;
            end
            ST_DIST: begin
                op_a   = {2'b00, mag_reg};
                op_b   = ~{{(ADD_W-SPD_W){1'b0}}, speed_mag};
                op_cin = 1'b1;
            end
            ST_NEXT: begin
                op_a = {{2{cur_reg[POS_W-1]}}, cur_reg};
                op_b = {{(ADD_W-SPD_W){speed_reg[SPD_W-1]}}, speed_reg};
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    assign sum = op_a + op_b + {{(ADD_W-1){1'b0}}, op_cin};

    // Saturate the new position to the signed 32-bit range.
    always_comb begin
        sat_pos = sum[POS_W-1:0];
        if (!sum[ADD_W-1] && (sum[ADD_W-2:POS_W-1] != 2'b00)) begin
            sat_pos = {1'b0, {(POS_W-1){1'b1}}};
        end else if (sum[ADD_W-1] && (sum[ADD_W-2:POS_W-1] != 2'b11)) begin
            sat_pos = {1'b1, {(POS_W-1){1'b0}}};
        end
    end

    // Speed moves one unit toward the wanted step unless that side is held off.
    always_comb begin
        speed_next = speed_reg;
        down_next  = down_reg;
        up_next    = up_reg;
        if ((speed_reg > wanted_reg) && (down_reg == '0)) begin
            speed_next = speed_reg - 1'b1;
            down_next  = reload;
        end else if ((speed_reg < wanted_reg) && (up_reg == '0)) begin
            speed_next = speed_reg + 1'b1;
            up_next    = reload;
        end else begin
            if (down_reg != '0) down_next = down_reg - 1'b1;
            if (up_reg != '0)   up_next   = up_reg - 1'b1;
        end
    end

    tpp_search #(
        .THR_W (THR_W)
    ) u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (search_start),
        .dist_i  (dist_reg),
        .size_i  (size),
        .accel_i (accel_period_reg),
        .res_o   (search_res)
    );

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        search_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) state_next = ST_DIFF;
            end
            ST_DIFF: state_next = ST_ABS;
            ST_ABS:  state_next = ST_DIST;
            ST_DIST: begin
                search_start = 1'b1;
                state_next   = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (search_res.done) state_next = ST_STEP;
            end
            ST_STEP:  state_next = ST_SPEED;
            ST_SPEED: state_next = ST_NEXT;
            ST_NEXT: begin
                // hold until the output register can take the item
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_speed_reg    <= MS_W'(16);
            accel_period_reg <= AP_W'(4);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_SPEED:    top_speed_reg    <= cfg_wdata[MS_W-1:0];
                CFG_ACCEL_PERIOD: accel_period_reg <= cfg_wdata;
                default:          top_speed_reg    <= top_speed_reg;
            endcase
        end
    end

    // Profile state: speed and hold-off counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= '0;
            down_reg  <= '0;
            up_reg    <= '0;
        end else if (state_reg == ST_SPEED) begin
            speed_reg <= speed_next;
            down_reg  <= down_next;
            up_reg    <= up_next;
        end
    end

    // Working registers of one item
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_reg  <= s_present_position;
                    goal_reg <= s_goal_position;
                end
            end
            ST_DIFF: diff_reg <= sum;
            ST_ABS:  mag_reg  <= sum[POS_W-1:0];
            // drop a negative remainder to zero
            ST_DIST: dist_reg <= sum[ADD_W-1] ? '0 : sum[POS_W-1:0];
            ST_SEARCH: begin
                if (search_res.done) inc_reg <= search_res.inc;
            end
            ST_STEP: begin
                // step magnitude is the smaller of distance and increment
                if (mag_reg <= {{(POS_W-MS_W){1'b0}}, inc_reg}) begin
                    wanted_reg <= dir_neg ? -$signed(mag_reg[SPD_W-1:0])
                                          : $signed(mag_reg[SPD_W-1:0]);
                end else begin
                    wanted_reg <= dir_neg ? -$signed({1'b0, inc_reg})
                                          : $signed({1'b0, inc_reg});
                end
            end
            default: begin
                wanted_reg <= wanted_reg;
            end
        endcase
    end

    // Output register: take a finished item, release it on m_ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_NEXT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_NEXT) && out_free) begin
            next_pos_reg  <= sat_pos;
            speed_out_reg <= speed_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_next_position = next_pos_reg;
    assign m_speed_now     = speed_out_reg;

    a_speed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (speed_reg <= $signed(SPD_W'(SIZE_MAX))) && (speed_reg >= -$signed(SPD_W'(SIZE_MAX))))
        else $error("profile speed beyond the threshold count");

    a_speed_only_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SPEED) |=> $stable(speed_reg))
        else $error("profile speed changed outside the update step");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DIFF))
        else $error("accepted item did not start the sequence");

    a_result_from_next: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_NEXT))
        else $error("result appeared outside the final step");

endmodule
